### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define VMN_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define VMN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define VMN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/vmn_pkg.sv
// ----------------------------------------------------------------------------
// vmn_pkg
// Shared widths, register codes, payload types and step functions of the
// vector magnitude normalizer.
// ----------------------------------------------------------------------------
package vmn_pkg;

  // Field and register widths
  localparam int FIELD_W    = 16;
  localparam int MAG_W      = 16;
  localparam int MSQ_W      = 2 * MAG_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Square root of (sum << 32): 32-bit radicand feed, 32-bit root
  localparam int RAD_W        = 32;
  localparam int ROOT_W       = 32;
  localparam int SQ_REM_W     = ROOT_W + 2;
  localparam int SQ_PER_STAGE = 2;
  localparam int SQ_STAGES    = ROOT_W / SQ_PER_STAGE;

  // Restoring division lanes, 16 quotient bits each
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = FIELD_W / DIV_PER_STAGE;
  localparam int LANES         = 4;
  localparam int LANE_MAG      = 0;
  localparam int LANE_X        = 1;
  localparam int MAP_NUM_W     = MAG_W + 1;

  // Register map (word index)
  localparam logic [CFG_ADDR_W-3:0] REG_MAX_MAG   = '0;
  localparam logic [MAG_W-1:0]      MAX_MAG_RESET = 16'hFFFF;

  // Saturation values
  localparam logic [FIELD_W-1:0] SAT_HIGH = '1;
  localparam logic [FIELD_W-1:0] SAT_LOW  = '0;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic [RAD_W-1:0]    rad;
  } sq_state_t;

  typedef struct packed {
    logic [MAG_W-1:0]   rem;
    logic [FIELD_W-1:0] qd;
  } div_lane_t;

  typedef div_lane_t [LANES-1:0] lanes_t;

  typedef logic [2:0][MAP_NUM_W-1:0] map_num_t;

  typedef struct packed {
    logic       mag_sat;
    logic [2:0] map_lo;
    logic [2:0] map_hi;
  } sat_flags_t;

  typedef struct packed {
    logic [FIELD_W-1:0] norm_magnitude;
    logic [FIELD_W-1:0] mapped_x;
    logic [FIELD_W-1:0] mapped_y;
    logic [FIELD_W-1:0] mapped_z;
    logic               clipped;
  } res_t;

  typedef struct packed {
    logic vld;
    res_t res;
  } res_beat_t;

  // Two digit-by-digit square root iterations
  function automatic sq_state_t sqrt_stage(input sq_state_t st_in);
    sq_state_t           st;
    logic [SQ_REM_W+1:0] acc;
    logic [SQ_REM_W+1:0] trial;
    st = st_in;
    for (int j = 0; j < SQ_PER_STAGE; j++) begin
      acc   = {st.rem, st.rad[RAD_W-1 -: 2]};
      trial = (SQ_REM_W + 2)'({st.root, 2'b01});
      if (acc >= trial) begin
        st.rem  = SQ_REM_W'(acc - trial);
        st.root = {st.root[ROOT_W-2:0], 1'b1};
      end else begin
        st.rem  = acc[SQ_REM_W-1:0];
        st.root = {st.root[ROOT_W-2:0], 1'b0};
      end
      st.rad = {st.rad[RAD_W-3:0], 2'b00};
    end
    return st;
  endfunction

  // Two restoring division steps on every lane
  function automatic lanes_t div_stage(input lanes_t ln_in, input logic [MAG_W-1:0] m);
    lanes_t         ln;
    logic [MAG_W:0] t;
    logic           ge;
    ln = ln_in;
    for (int l = 0; l < LANES; l++) begin
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
        t  = {ln[l].rem, ln[l].qd[FIELD_W-1]};
        ge = (t >= {1'b0, m});
        if (ge) begin
          ln[l].rem = MAG_W'(t - {1'b0, m});
        end else begin
          ln[l].rem = t[MAG_W-1:0];
        end
        ln[l].qd = {ln[l].qd[FIELD_W-2:0], ge};
      end
    end
    return ln;
  endfunction

endpackage

### design/vmn_in_if.sv
// ----------------------------------------------------------------------------
// vmn_in_if
// Valid/ready channel carrying one velocity voxel (three signed components).
// ----------------------------------------------------------------------------
interface vmn_in_if #(parameter int COMP_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] comp_x;
  logic signed [COMP_WIDTH-1:0] comp_y;
  logic signed [COMP_WIDTH-1:0] comp_z;

  modport source (output valid, output comp_x, output comp_y, output comp_z, input ready);
  modport sink   (input valid, input comp_x, input comp_y, input comp_z, output ready);
endinterface

### design/vmn_out_if.sv
// ----------------------------------------------------------------------------
// vmn_out_if
// Valid/ready channel carrying one normalized result.
// ----------------------------------------------------------------------------
interface vmn_out_if import vmn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] norm_magnitude;
  logic [FIELD_W-1:0] mapped_x;
  logic [FIELD_W-1:0] mapped_y;
  logic [FIELD_W-1:0] mapped_z;
  logic               clipped;

  modport source (output valid, output norm_magnitude, output mapped_x, output mapped_y,
                  output mapped_z, output clipped, input ready);
  modport sink   (input valid, input norm_magnitude, input mapped_x, input mapped_y,
                  input mapped_z, input clipped, output ready);
endinterface

### design/vmn_pipe.sv
// ----------------------------------------------------------------------------
// vmn_pipe
// Datapath pipeline: abs and squares, sum and range checks, pipelined square
// root of (sum << 32), then four restoring division lanes by max_magnitude.
// ----------------------------------------------------------------------------
module vmn_pipe import vmn_pkg::*; #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_take,
  input  logic signed [COMP_WIDTH-1:0] comp_x,
  input  logic signed [COMP_WIDTH-1:0] comp_y,
  input  logic signed [COMP_WIDTH-1:0] comp_z,
  input  logic [MAG_W-1:0]             max_magnitude,
  output res_beat_t                    push
);

  localparam int SUM_W  = 2 * COMP_WIDTH;
  localparam int CMP_W  = (SUM_W > MSQ_W) ? SUM_W : MSQ_W;
  localparam int NUM_W  = ((COMP_WIDTH > MAP_NUM_W) ? COMP_WIDTH : MAP_NUM_W) + 1;
  localparam int NSTAGE = 3 + SQ_STAGES + DIV_STAGES;

  logic [MAG_W-1:0]             m_eff;
  logic [MSQ_W-1:0]             msq_r;
  logic [NSTAGE-1:0]            vld_r;

  logic signed [COMP_WIDTH-1:0] comp_in  [3];
  logic [COMP_WIDTH-1:0]        abs_nxt  [3];
  logic signed [COMP_WIDTH-1:0] comp_r   [3];
  logic [COMP_WIDTH-1:0]        abs_r    [3];
  logic [SUM_W-1:0]             sqr_nxt  [3];
  logic signed [NUM_W-1:0]      num_nxt  [3];
  logic [SUM_W-1:0]             sqr_r    [3];
  logic signed [NUM_W-1:0]      num_r    [3];

  logic [SUM_W-1:0]             sum;
  sq_state_t                    rt_nxt;
  sat_flags_t                   fl_nxt;
  map_num_t                     mn_nxt;
  sq_state_t                    rt_r  [0:SQ_STAGES];
  sat_flags_t                   fl_r  [0:SQ_STAGES];
  map_num_t                     mn_r  [0:SQ_STAGES];

  lanes_t                       dv_init;
  lanes_t                       dv_r  [0:DIV_STAGES-1];
  sat_flags_t                   dfl_r [0:DIV_STAGES-1];
  lanes_t                       dv_last;
  sat_flags_t                   fl_last;

  assign comp_in[0] = comp_x;
  assign comp_in[1] = comp_y;
  assign comp_in[2] = comp_z;

  // A maximum of zero acts as one
  assign m_eff = (max_magnitude == '0) ? MAG_W'(1) : max_magnitude;

  // Square of the maximum, follows the register
  always_ff @(posedge clk) begin
    msq_r <= MSQ_W'(m_eff) * MSQ_W'(m_eff);
  end

  // Stage 0 input: absolute values
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_nxt[i] = comp_in[i][COMP_WIDTH-1] ? COMP_WIDTH'(~comp_in[i] + 1'b1) : comp_in[i];
    end
  end

  // Stage 1 input: squares and component plus maximum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqr_nxt[i] = SUM_W'(abs_r[i]) * SUM_W'(abs_r[i]);
      num_nxt[i] = NUM_W'(comp_r[i]) + $signed(NUM_W'(m_eff));
    end
  end

  // Stage 2 input: sum of squares, saturation checks, root seed
  always_comb begin
    sum            = sqr_r[0] + sqr_r[1] + sqr_r[2];
    fl_nxt.mag_sat = (CMP_W'(sum) >= CMP_W'(msq_r));
    for (int i = 0; i < 3; i++) begin
      fl_nxt.map_lo[i] = num_r[i][NUM_W-1];
      fl_nxt.map_hi[i] = !num_r[i][NUM_W-1] &&
                         (NUM_W'($unsigned(num_r[i])) >= NUM_W'({m_eff, 1'b0}));
      mn_nxt[i]        = num_r[i][MAP_NUM_W-1:0];
    end
    rt_nxt = '{rem: '0, root: '0, rad: RAD_W'(sum)};
  end

  // Division seeds: root over max, and (component + max) * 2^15 over max
  always_comb begin
    dv_init[LANE_MAG] = '{rem: rt_r[SQ_STAGES].root[ROOT_W-1 -: MAG_W],
                          qd:  rt_r[SQ_STAGES].root[FIELD_W-1:0]};
    for (int i = 0; i < 3; i++) begin
      dv_init[LANE_X+i] = '{rem: mn_r[SQ_STAGES][i][MAP_NUM_W-1:1],
                            qd:  {mn_r[SQ_STAGES][i][0], {(FIELD_W-1){1'b0}}}};
    end
  end

  // Advance all payload stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        comp_r[i] <= comp_in[i];
        abs_r[i]  <= abs_nxt[i];
        sqr_r[i]  <= sqr_nxt[i];
        num_r[i]  <= num_nxt[i];
      end
      rt_r[0] <= rt_nxt;
      fl_r[0] <= fl_nxt;
      mn_r[0] <= mn_nxt;
      for (int k = 0; k < SQ_STAGES; k++) begin
        rt_r[k+1] <= sqrt_stage(rt_r[k]);
        fl_r[k+1] <= fl_r[k];
        mn_r[k+1] <= mn_r[k];
      end
      dv_r[0]  <= div_stage(dv_init, m_eff);
      dfl_r[0] <= fl_r[SQ_STAGES];
      for (int d = 1; d < DIV_STAGES; d++) begin
        dv_r[d]  <= div_stage(dv_r[d-1], m_eff);
        dfl_r[d] <= dfl_r[d-1];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_take};
    end
  end

  // Apply saturation and hand the result to the output buffer
  always_comb begin
    dv_last  = dv_r[DIV_STAGES-1];
    fl_last  = dfl_r[DIV_STAGES-1];
    push.vld = vld_r[NSTAGE-1] && en;
    push.res.norm_magnitude = fl_last.mag_sat ? SAT_HIGH : dv_last[LANE_MAG].qd;
    push.res.mapped_x = fl_last.map_lo[0] ? SAT_LOW :
                        (fl_last.map_hi[0] ? SAT_HIGH : dv_last[LANE_X].qd);
    push.res.mapped_y = fl_last.map_lo[1] ? SAT_LOW :
                        (fl_last.map_hi[1] ? SAT_HIGH : dv_last[LANE_X+1].qd);
    push.res.mapped_z = fl_last.map_lo[2] ? SAT_LOW :
                        (fl_last.map_hi[2] ? SAT_HIGH : dv_last[LANE_X+2].qd);
    push.res.clipped  = fl_last.mag_sat | (|fl_last.map_lo) | (|fl_last.map_hi);
  end

endmodule

### design/vmn_obuf.sv
// ----------------------------------------------------------------------------
// vmn_obuf
// Two-entry output buffer. Its fill level sets the pipeline advance enable,
// so the receiver's ready never reaches the input side combinationally.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vmn_obuf import vmn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_beat_t push,
  output logic      pipe_en,
  output logic      out_valid,
  input  logic      out_ready,
  output res_t      out_res
);

  localparam logic [1:0] BUF_EMPTY = 2'd0;
  localparam logic [1:0] BUF_ONE   = 2'd1;
  localparam logic [1:0] BUF_FULL  = 2'd2;

  logic [1:0] count_r, count_nxt;
  logic       run_r;
  res_t       head_r, head_nxt;
  res_t       skid_r, skid_nxt;
  logic       pop;

  assign out_valid = (count_r != BUF_EMPTY);
  assign out_res   = head_r;
  assign pop       = out_valid && out_ready;
  assign pipe_en   = run_r && (count_r != BUF_FULL);

  // Track fill level and route each transaction to head or skid entry
  always_comb begin
    count_nxt = count_r + 2'(push.vld) - 2'(pop);
    head_nxt  = head_r;
    skid_nxt  = skid_r;
    if (pop && count_r == BUF_FULL) begin
      head_nxt = skid_r;
    end else if (push.vld && (count_r == BUF_EMPTY || (pop && count_r == BUF_ONE))) begin
      head_nxt = push.res;
    end
    if (push.vld && count_r == BUF_ONE && !pop) begin
      skid_nxt = push.res;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= BUF_EMPTY;
      run_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      run_r   <= 1'b1;
    end
  end

  // Payload entries
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  `VMN_ASSERT(a_count_range, count_r != 2'd3)
  `VMN_ASSERT_IMPL(a_no_push_when_full, push.vld, count_r != BUF_FULL)
  `VMN_ASSERT_NEXT(a_full_holds, (count_r == BUF_FULL) && !pop, count_r == BUF_FULL)
  `VMN_ASSERT_NEXT(a_skid_moves_up, (count_r == BUF_FULL) && pop, head_r == $past(skid_r))

endmodule

### design/vector_magnitude_normalizer.sv
// ----------------------------------------------------------------------------
// vector_magnitude_normalizer
// Maps one velocity voxel per transaction to a normalized magnitude and three
// offset-mapped components, all unsigned Q0.16 with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready, one voxel (comp_x, comp_y, comp_z) per transaction.
//   out_ch : valid/ready, one result per voxel, in arrival order.
//   APB    : word 0 is max_magnitude (16 bits, 0 acts as 1). Write it only
//            while no voxel is in flight.
// Pipeline: 28 register stages: abs, squares, sum/range check, 16 square root
//   stages of two root bits each, 8 division stages of two quotient bits each,
//   then the output register.
// Throughput: one voxel per cycle unless the output buffer is full; the square
//   root and division stages are fully pipelined, so the per-stage add/compare
//   sets the clock, not the rate.
// Reset: clears all valid bits and the output buffer and loads max_magnitude
//   with 65535; in_ch.ready rises in the cycle after reset is released.
// Stall: a two-entry output buffer holds results while out_ch.ready is low;
//   once both entries are full the whole pipeline freezes and in_ch.ready drops.
// ----------------------------------------------------------------------------
module vector_magnitude_normalizer import vmn_pkg::*; #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vmn_in_if.sink                in_ch,
  vmn_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [MAG_W-1:0] max_mag_r, max_mag_nxt;
  logic             cfg_wr;
  logic             pipe_en;
  logic             in_take;
  res_beat_t        push;
  res_t             out_res;

  // Register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    max_mag_nxt = max_mag_r;
    if (cfg_wr) begin
      unique case (paddr[CFG_ADDR_W-1:2])
        REG_MAX_MAG: max_mag_nxt = pwdata[MAG_W-1:0];
        default:     max_mag_nxt = max_mag_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[CFG_ADDR_W-1:2])
      REG_MAX_MAG: prdata = CFG_DATA_W'(max_mag_r);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mag_r <= MAX_MAG_RESET;
    end else begin
      max_mag_r <= max_mag_nxt;
    end
  end

  // Input handshake
  assign in_ch.ready = pipe_en;
  assign in_take     = in_ch.valid && pipe_en;

  vmn_pipe #(
    .COMP_WIDTH (COMP_WIDTH)
  ) u_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (pipe_en),
    .in_take       (in_take),
    .comp_x        (in_ch.comp_x),
    .comp_y        (in_ch.comp_y),
    .comp_z        (in_ch.comp_z),
    .max_magnitude (max_mag_r),
    .push          (push)
  );

  vmn_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pipe_en   (pipe_en),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // Result channel payload
  assign out_ch.norm_magnitude = out_res.norm_magnitude;
  assign out_ch.mapped_x       = out_res.mapped_x;
  assign out_ch.mapped_y       = out_res.mapped_y;
  assign out_ch.mapped_z       = out_res.mapped_z;
  assign out_ch.clipped        = out_res.clipped;

endmodule

### verif/vector_magnitude_normalizer_tb.sv
// ----------------------------------------------------------------------------
// vector_magnitude_normalizer_tb
// Streams velocity voxels through the normalizer with random gaps on the
// input side and random stalls on the result side. A behavioral predictor
// computes the saturated magnitude and the three mapped components for each
// accepted voxel. Every result is compared field by field, in order, against
// the oldest prediction. The maximum magnitude register is rewritten over the
// APB port between phases, the extremes among them.
// ----------------------------------------------------------------------------
module vector_magnitude_normalizer_tb;
  import vmn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COMP_W = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [CFG_ADDR_W-3:0] REG_UNMAPPED = 1'b1;

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } voxel_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  vmn_in_if #(.COMP_WIDTH(COMP_W)) in_ch ();
  vmn_out_if                       out_ch ();

  vector_magnitude_normalizer #(.COMP_WIDTH(COMP_W)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state and scoreboard
  logic [MAG_W-1:0] max_mag_shadow;
  res_t             expected_texels[$];
  int               mismatch_count;
  bit               src_burst;
  bit               sink_burst;

  // Clock: 4 ns period
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Compute the expected result of one voxel under a given register value
  function automatic res_t normalize_voxel(input voxel_t v, input logic [MAG_W-1:0] max_reg);
    res_t              r;
    longint            comp[3];
    longint            m;
    longint            num;
    longint unsigned   sum_sq;
    longint unsigned   rad;
    longint unsigned   prod;
    longint unsigned   q;
    longint unsigned   trial;
    logic [FIELD_W-1:0] mapped[3];
    comp[0] = v.x;
    comp[1] = v.y;
    comp[2] = v.z;
    m = (max_reg == '0) ? 1 : longint'(max_reg);
    r = '0;
    sum_sq = 0;
    for (int i = 0; i < 3; i++) begin
      sum_sq += longint'(comp[i] * comp[i]);
    end
    // Magnitude: saturate at or above one, else bitwise root search
    if (sum_sq >= longint'(m * m)) begin
      r.norm_magnitude = SAT_HIGH;
      r.clipped = 1'b1;
    end else begin
      rad = sum_sq << 32;
      q = 0;
      for (int b = FIELD_W - 1; b >= 0; b--) begin
        trial = q | (64'd1 << b);
        prod = trial * longint'(m);
        if (prod * prod <= rad) q = trial;
      end
      r.norm_magnitude = q[FIELD_W-1:0];
    end
    // Components: offset by max, scale by half of one over max
    for (int i = 0; i < 3; i++) begin
      num = comp[i] + m;
      if (num < 0) begin
        mapped[i] = SAT_LOW;
        r.clipped = 1'b1;
      end else if (num >= 2 * m) begin
        mapped[i] = SAT_HIGH;
        r.clipped = 1'b1;
      end else begin
        mapped[i] = FIELD_W'((num * 32768) / m);
      end
    end
    r.mapped_x = mapped[0];
    r.mapped_y = mapped[1];
    r.mapped_z = mapped[2];
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One random component, biased toward the unsaturated band and its edges
  function automatic logic signed [COMP_W-1:0] pick_component(input logic [MAG_W-1:0] max_reg);
    int unsigned mode;
    int          span;
    int          val;
    mode = $urandom_range(0, 9);
    span = (max_reg == '0) ? 1 : int'(max_reg);
    if (mode < 3) begin
      val = int'($urandom_range(0, 65535)) - 32768;
    end else if (mode < 8) begin
      val = int'($urandom_range(0, 2 * span)) - span;
    end else begin
      val = ($urandom_range(0, 1) ? span : -span) + int'($urandom_range(0, 2)) - 1;
    end
    if (val > 32767) val = 32767;
    if (val < -32768) val = -32768;
    return COMP_W'(val);
  endfunction

  task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] want,
                                 input logic [FIELD_W-1:0] got);
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Send one voxel, record its prediction on acceptance, then idle
  task automatic send_voxel(input voxel_t v);
    int gap;
    in_ch.valid  <= 1'b1;
    in_ch.comp_x <= v.x;
    in_ch.comp_y <= v.y;
    in_ch.comp_z <= v.z;
    do @(posedge clk); while (!in_ch.ready);
    expected_texels = {expected_texels, normalize_voxel(v, max_mag_shadow)};
    gap = src_burst ? 0 : pick_idle();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_xyz(input int x, input int y, input int z);
    voxel_t v;
    v.x = COMP_W'(x);
    v.y = COMP_W'(y);
    v.z = COMP_W'(z);
    send_voxel(v);
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic write_register(input logic [CFG_ADDR_W-3:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MAX_MAG) max_mag_shadow = data[MAG_W-1:0];
  endtask

  // APB read: setup cycle, then sample read data on the access edge
  task automatic read_register(input logic [CFG_ADDR_W-3:0] idx,
                               output logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random stalls, with burst stretches
  always @(posedge clk) begin : sink_ready_gen
    static int hold = 0;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold > 0) begin
      out_ch.ready <= 1'b0;
      hold--;
    end else if (!sink_burst && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      hold = pick_idle();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_texels.size() == 0) begin
        $display("[%0t] result with no voxel outstanding", $time);
        mismatch_count++;
      end else begin
        want = expected_texels.pop_front();
        if (out_ch.norm_magnitude !== want.norm_magnitude)
          report_mismatch("norm_magnitude", want.norm_magnitude, out_ch.norm_magnitude);
        if (out_ch.mapped_x !== want.mapped_x)
          report_mismatch("mapped_x", want.mapped_x, out_ch.mapped_x);
        if (out_ch.mapped_y !== want.mapped_y)
          report_mismatch("mapped_y", want.mapped_y, out_ch.mapped_y);
        if (out_ch.mapped_z !== want.mapped_z)
          report_mismatch("mapped_z", want.mapped_z, out_ch.mapped_z);
        if (out_ch.clipped !== want.clipped)
          report_mismatch("clipped", FIELD_W'(want.clipped), FIELD_W'(out_ch.clipped));
      end
    end
  end

  // Reset value of the register with the component extremes
  task automatic test_reset_extremes();
    send_xyz(0, 0, 0);
    send_xyz(32767, 32767, 32767);
    send_xyz(-32768, -32768, -32768);
    send_xyz(32767, -32768, 0);
    send_xyz(1, -1, 21845);
    send_xyz(-21846, 0, -1);
    drain();
  endtask

  // Values landing exactly on one, just below one and just below zero
  task automatic test_exact_one();
    write_register(REG_MAX_MAG, 32'd100);
    send_xyz(100, 0, 0);
    send_xyz(60, 80, 0);
    send_xyz(60, 79, 0);
    send_xyz(-100, 0, 99);
    send_xyz(-101, 0, 0);
    send_xyz(0, -99, 0);
    drain();
  endtask

  // A zero maximum behaves as a maximum of one
  task automatic test_zero_max();
    write_register(REG_MAX_MAG, 32'd0);
    send_xyz(0, 0, 0);
    send_xyz(1, 0, 0);
    send_xyz(0, -1, 0);
    send_xyz(0, 0, -2);
    drain();
  endtask

  // Upper data bits and writes to an unmapped word leave the register alone
  task automatic test_register_decode();
    logic [CFG_DATA_W-1:0] rd;
    write_register(REG_MAX_MAG, 32'hFFFF_0007);
    write_register(REG_UNMAPPED, 32'h0000_1234);
    read_register(REG_MAX_MAG, rd);
    if (rd !== CFG_DATA_W'(max_mag_shadow))
      report_mismatch("max_magnitude readback", max_mag_shadow, FIELD_W'(rd));
    send_xyz(3, -4, 7);
    send_xyz(-7, 6, 2);
    drain();
    write_register(REG_MAX_MAG, 32'h0001_FFFF);
    send_xyz(12345, -23456, 30000);
    drain();
  endtask

  // Random voxels under one register setting, optionally pausing midway
  task automatic test_random_phase(input logic [MAG_W-1:0] max_val, input int n_items,
                                   input bit mid_pause);
    voxel_t v;
    write_register(REG_MAX_MAG, CFG_DATA_W'(max_val));
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        src_burst  = ($urandom_range(0, 3) == 0);
        sink_burst = ($urandom_range(0, 3) == 0);
      end
      if (mid_pause && i == n_items / 2) drain();
      v.x = pick_component(max_val);
      v.y = pick_component(max_val);
      v.z = pick_component(max_val);
      send_voxel(v);
    end
    drain();
  endtask

  initial begin
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.comp_x <= '0;
    in_ch.comp_y <= '0;
    in_ch.comp_z <= '0;
    max_mag_shadow = MAX_MAG_RESET;
    mismatch_count = 0;
    src_burst  = 1'b0;
    sink_burst = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_extremes();
    test_exact_one();
    test_zero_max();
    test_register_decode();
    test_random_phase(16'hFFFF, 100, 1'b1);
    test_random_phase(16'h0001, 100, 1'b0);
    test_random_phase(MAG_W'($urandom_range(2, 300)), 100, 1'b0);
    test_random_phase(MAG_W'($urandom_range(1, 65535)), 100, 1'b1);
    test_random_phase(16'h8000, 100, 1'b0);
    test_random_phase(16'h0000, 100, 1'b0);

    // Let any stray result surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_texels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
